// ===== rtl/core/nnsa_pkg.sv =====
`default_nettype none

package nnsa_pkg;

    // Field widths fixed by the interface
    localparam int CFG_W       = 13;
    localparam int COORD_W     = 12;
    localparam int INDEX_W     = 24;
    localparam int NUM_W       = COORD_W + CFG_W;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_DIM_DEF = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_idx_t;

    // Effective image sizes, already clamped to 1..MAX_DIM
    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
    } dims_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [INDEX_W-1:0] src_index;
        logic [INDEX_W-1:0] dst_index;
        logic               coord_invalid;
    } out_t;

    // Side information that rides along the divider
    typedef struct packed {
        logic               coord_invalid;
        logic [INDEX_W-1:0] dst_index;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/nearest_neighbor_scale_address_core.sv =====
`default_nettype none

// Nearest-neighbor scaling address generator. Pulse start with a destination
// coordinate in item; once the item has passed the stage A and stage B
// registers, the divider stages and the output register, done is high for one
// cycle with the source column and row, the linear source and destination
// indexes, and coord_invalid. A new item may be started in every cycle, so the
// sustained rate is one item per clock; the two-lane restoring divider retires
// one of the Q_W = clog2(MAX_DIM) quotient bits per pipeline stage. busy is
// always low. There is no back-pressure on the result side: the receiver must
// take each result in the cycle that done marks it. Write the size registers
// only while no item is in flight; a written value of zero acts as one and a
// value above MAX_DIM acts as MAX_DIM.
module nearest_neighbor_scale_address_core #(
    parameter int MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire nnsa_pkg::in_t                  item,
    output logic                                done,
    output nnsa_pkg::out_t                      result,
    input  wire logic                           cfg_we,
    input  wire logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nnsa_pkg::CFG_W-1:0]     cfg_data
);

    // Quotient width: a valid quotient stays below the source size
    localparam int Q_W   = $clog2(MAX_DIM);
    localparam int TAG_W = $bits(nnsa_pkg::side_t);
    localparam int PW    = Q_W + nnsa_pkg::CFG_W + 1;
    localparam int LAT   = Q_W + 3;

    nnsa_pkg::dims_t dims;

    nnsa_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims)
    );

    // The pipeline never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // Stage A: capture the item and range-check it
    // ---------------------------------------------------------------------
    logic                         a_valid_reg;
    logic [nnsa_pkg::COORD_W-1:0] a_x_reg;
    logic [nnsa_pkg::COORD_W-1:0] a_y_reg;
    logic                         a_invalid_reg;
    logic                         a_invalid_next;

    assign a_invalid_next = ({1'b0, item.out_x} >= dims.dst_width)
                         || ({1'b0, item.out_y} >= dims.dst_height);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg       <= item.out_x;
        a_y_reg       <= item.out_y;
        a_invalid_reg <= a_invalid_next;
    end

    // ---------------------------------------------------------------------
    // Stage B: scale products (dividends) and the destination index
    // ---------------------------------------------------------------------
    logic                       b_valid_reg;
    logic [nnsa_pkg::NUM_W-1:0] b_num_reg [2];
    nnsa_pkg::side_t            b_side_reg;
    nnsa_pkg::side_t            b_side_next;
    logic [nnsa_pkg::NUM_W-1:0] b_num_x_next;
    logic [nnsa_pkg::NUM_W-1:0] b_num_y_next;
    logic [nnsa_pkg::NUM_W-1:0] b_dst_full;

    always_comb
    begin
        b_num_x_next = nnsa_pkg::NUM_W'(a_x_reg) * nnsa_pkg::NUM_W'(dims.src_width);
        b_num_y_next = nnsa_pkg::NUM_W'(a_y_reg) * nnsa_pkg::NUM_W'(dims.src_height);
        b_dst_full   = nnsa_pkg::NUM_W'(a_y_reg) * nnsa_pkg::NUM_W'(dims.dst_width)
                     + nnsa_pkg::NUM_W'(a_x_reg);
        b_side_next.coord_invalid = a_invalid_reg;
        b_side_next.dst_index     = b_dst_full[nnsa_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_num_reg[0] <= b_num_x_next;
        b_num_reg[1] <= b_num_y_next;
        b_side_reg   <= b_side_next;
    end

    // ---------------------------------------------------------------------
    // Divider stages: lane 0 is the column, lane 1 the row
    // ---------------------------------------------------------------------
    logic [nnsa_pkg::CFG_W-1:0] div_den [2];
    logic                       d_valid;
    logic [Q_W-1:0]             d_quo [2];
    logic [TAG_W-1:0]           d_tag;
    nnsa_pkg::side_t            d_side;

    assign div_den[0] = dims.dst_width;
    assign div_den[1] = dims.dst_height;

    nnsa_div #(
        .Q_W   (Q_W),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (b_num_reg),
        .den       (div_den),
        .tag_in    (b_side_reg),
        .out_valid (d_valid),
        .quo       (d_quo),
        .tag_out   (d_tag)
    );

    assign d_side = nnsa_pkg::side_t'(d_tag);

    // ---------------------------------------------------------------------
    // Output stage: source index, zero all other fields for an invalid item
    // ---------------------------------------------------------------------
    logic           done_reg;
    nnsa_pkg::out_t result_reg;
    nnsa_pkg::out_t result_next;
    logic [PW-1:0]  src_full;

    always_comb
    begin
        src_full = PW'(d_quo[1]) * PW'(dims.src_width) + PW'(d_quo[0]);
        if (d_side.coord_invalid)
        begin
            result_next               = '0;
            result_next.coord_invalid = 1'b1;
        end
        else
        begin
            result_next.src_x         = nnsa_pkg::COORD_W'(d_quo[0]);
            result_next.src_y         = nnsa_pkg::COORD_W'(d_quo[1]);
            result_next.src_index     = nnsa_pkg::INDEX_W'(src_full);
            result_next.dst_index     = d_side.dst_index;
            result_next.coord_invalid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("item started but no result after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching started item");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.coord_invalid |->
            result.src_x == '0 && result.src_y == '0 &&
            result.src_index == '0 && result.dst_index == '0)
        else $error("invalid coordinate gave nonzero fields");

    a_src_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.coord_invalid |->
            32'(result.src_x) < 32'(dims.src_width) &&
            32'(result.src_y) < 32'(dims.src_height))
        else $error("source coordinate outside source image");

endmodule

`default_nettype wire

// ===== rtl/core/nnsa_cfg.sv =====
`default_nettype none

module nnsa_cfg #(
    parameter int MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nnsa_pkg::CFG_W-1:0]     cfg_data,
    output nnsa_pkg::dims_t                     dims
);

    nnsa_pkg::dims_t            dims_reg;
    logic [nnsa_pkg::CFG_W-1:0] eff;

    // Clamp at write time: zero reads as one, oversize saturates
    always_comb
    begin
        if (cfg_data == '0)
        begin
            eff = nnsa_pkg::CFG_W'(1);
        end
        else if (32'(cfg_data) > MAX_DIM)
        begin
            eff = nnsa_pkg::CFG_W'(MAX_DIM);
        end
        else
        begin
            eff = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.src_width  <= nnsa_pkg::CFG_W'(1);
            dims_reg.src_height <= nnsa_pkg::CFG_W'(1);
            dims_reg.dst_width  <= nnsa_pkg::CFG_W'(1);
            dims_reg.dst_height <= nnsa_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (nnsa_pkg::reg_idx_t'(cfg_index))
                nnsa_pkg::REG_SRC_WIDTH:  dims_reg.src_width  <= eff;
                nnsa_pkg::REG_SRC_HEIGHT: dims_reg.src_height <= eff;
                nnsa_pkg::REG_DST_WIDTH:  dims_reg.dst_width  <= eff;
                nnsa_pkg::REG_DST_HEIGHT: dims_reg.dst_height <= eff;
            endcase
        end
    end

    assign dims = dims_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nnsa_div.sv =====
`default_nettype none

// Two-lane pipelined restoring divider, one quotient bit per stage.
// The caller must hold divisors steady while items are in flight (unchecked).
module nnsa_div #(
    parameter int Q_W   = 12,
    parameter int TAG_W = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [nnsa_pkg::NUM_W-1:0] num [2],
    input  wire logic [nnsa_pkg::CFG_W-1:0] den [2],
    input  wire logic [TAG_W-1:0]           tag_in,
    output logic                            out_valid,
    output logic [Q_W-1:0]                  quo [2],
    output logic [TAG_W-1:0]                tag_out
);

    localparam int LANES = 2;

    logic                       vld_reg [Q_W];
    logic [TAG_W-1:0]           tag_reg [Q_W];
    logic [nnsa_pkg::CFG_W-1:0] rem_reg [Q_W][LANES];
    logic [Q_W-1:0]             low_reg [Q_W][LANES];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic                       v_src;
        logic [TAG_W-1:0]           tag_src;
        logic [nnsa_pkg::CFG_W-1:0] rem_src  [LANES];
        logic [Q_W-1:0]             low_src  [LANES];
        logic [nnsa_pkg::CFG_W-1:0] rem_next [LANES];
        logic [Q_W-1:0]             low_next [LANES];

        if (k == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign tag_src = tag_in;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                // High part is below the divisor for any in-range item
                assign rem_src[l] = nnsa_pkg::CFG_W'(num[l][nnsa_pkg::NUM_W-1:Q_W]);
                assign low_src[l] = num[l][Q_W-1:0];
            end
        end
        else
        begin : g_next
            assign v_src   = vld_reg[k-1];
            assign tag_src = tag_reg[k-1];
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l] = rem_reg[k-1][l];
                assign low_src[l] = low_reg[k-1][l];
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_step
            logic [nnsa_pkg::CFG_W:0] trial;
            logic [nnsa_pkg::CFG_W:0] diff;
            logic                     ge;

            always_comb
            begin
                trial       = {rem_src[l], low_src[l][Q_W-1]};
                diff        = trial - {1'b0, den[l]};
                ge          = (trial >= {1'b0, den[l]});
                rem_next[l] = ge ? diff[nnsa_pkg::CFG_W-1:0] : trial[nnsa_pkg::CFG_W-1:0];
                low_next[l] = {low_src[l][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k] <= tag_src;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[k][l] <= rem_next[l];
                low_reg[k][l] <= low_next[l];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign tag_out   = tag_reg[Q_W-1];
    assign quo[0]    = low_reg[Q_W-1][0];
    assign quo[1]    = low_reg[Q_W-1][1];

endmodule

`default_nettype wire
